>>> src/bdf_pkg.sv
// shared types, constants and ita2 tables for the baudot deframer
package bdf_pkg;

	localparam int unsigned PHASE_WIDTH_DEF = 32;
	localparam int unsigned STEP_WIDTH      = 32;
	localparam int unsigned CODE_WIDTH      = 5;
	localparam int unsigned CHAR_WIDTH      = 7;
	localparam int unsigned COUNT_WIDTH     = 3;
	localparam int unsigned QUEUE_DEPTH     = 2;

	localparam logic [STEP_WIDTH-1:0] BAUD_STEP_RESET = 32'd4473924;
	localparam logic [CODE_WIDTH-1:0] CODE_LTRS       = 5'h1F;
	localparam logic [CODE_WIDTH-1:0] CODE_FIGS       = 5'h1B;
	localparam logic [CODE_WIDTH-1:0] CODE_NULL       = 5'h00;
	localparam logic [CHAR_WIDTH-1:0] CHAR_SPACE      = 7'h20;
	localparam logic [COUNT_WIDTH-1:0] BITS_PER_CODE  = 3'd5;

	typedef logic [CODE_WIDTH-1:0] code_t;
	typedef logic [CHAR_WIDTH-1:0] char_t;

	// one code word moving between front, queue and back
	typedef struct packed {
		logic  valid;
		code_t code;
	} code_word_t;

	localparam char_t LTRS_TAB [32] = '{
		7'h20, 7'h20, 7'h45, 7'h0A, 7'h41, 7'h20, 7'h53, 7'h49,
		7'h55, 7'h0D, 7'h44, 7'h52, 7'h4A, 7'h4E, 7'h46, 7'h43,
		7'h4B, 7'h54, 7'h5A, 7'h4C, 7'h57, 7'h48, 7'h59, 7'h50,
		7'h51, 7'h4F, 7'h42, 7'h47, 7'h20, 7'h4D, 7'h58, 7'h56
	};

	localparam char_t FIGS_TAB [32] = '{
		7'h20, 7'h20, 7'h33, 7'h0A, 7'h2D, 7'h20, 7'h38, 7'h37,
		7'h27, 7'h37, 7'h34, 7'h20, 7'h34, 7'h35, 7'h2C, 7'h3A,
		7'h21, 7'h3F, 7'h20, 7'h22, 7'h39, 7'h30, 7'h2B, 7'h31,
		7'h35, 7'h36, 7'h31, 7'h20, 7'h31, 7'h32, 7'h20, 7'h20
	};

	function automatic char_t ita2_lookup(input logic figures, input code_t code);
		char_t ch;
		if (figures) begin
			ch = FIGS_TAB[code];
		end else begin
			ch = LTRS_TAB[code];
		end
		return ch;
	endfunction

endpackage

>>> src/bdf_front.sv
// front end: phase accumulator, start/data/stop framing, code word assembly
module bdf_front #(
	parameter int unsigned PHASE_WIDTH = bdf_pkg::PHASE_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [bdf_pkg::STEP_WIDTH-1:0]      baud_step,
	input  logic                                in_valid,
	input  logic                                line_bit,
	input  logic                                queue_full,
	output bdf_pkg::code_word_t                 push
);
	import bdf_pkg::*;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_START,
		PH_DATA,
		PH_STOP
	} phase_t;

	localparam logic [PHASE_WIDTH-1:0] HALF_SCALE = {1'b1, {(PHASE_WIDTH-1){1'b0}}};

	phase_t                  phase_q;
	logic [PHASE_WIDTH-1:0]  acc_q;
	logic [STEP_WIDTH-1:0]   baud_q;
	code_t                   code_q;
	logic [COUNT_WIDTH-1:0]  cnt_q;

	logic                    accept;
	logic [PHASE_WIDTH-1:0]  step_w;
	logic [PHASE_WIDTH-1:0]  sum;
	logic                    carry;
	code_t                   code_next;
	logic [COUNT_WIDTH-1:0]  cnt_next;
	logic                    last_bit;

	assign accept = in_valid && !queue_full;
	assign step_w = PHASE_WIDTH'(baud_q);

	always_comb begin
		{carry, sum} = {1'b0, acc_q} + {1'b0, step_w};
		code_next    = code_q | (CODE_WIDTH'(line_bit) << cnt_q);
		cnt_next     = cnt_q + 3'd1;
		last_bit     = (cnt_next == BITS_PER_CODE);
	end

	// null code never leaves the front end
	always_comb begin
		push.valid = accept && (phase_q == PH_DATA) && carry && last_bit
			&& (code_next != CODE_NULL);
		push.code  = code_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			baud_q  <= BAUD_STEP_RESET;
			code_q  <= '0;
			cnt_q   <= '0;
		end else begin
			if (cfg_valid) begin
				baud_q <= baud_step;
			end
			if (accept) begin
				unique case (phase_q)
					PH_IDLE: begin
						if (!line_bit) begin
							phase_q <= PH_START;
							acc_q   <= HALF_SCALE;
						end
					end
					PH_START: begin
						acc_q <= sum;
						if (carry) begin
							if (!line_bit) begin
								phase_q <= PH_DATA;
								acc_q   <= '0;
								code_q  <= '0;
								cnt_q   <= '0;
							end else begin
								phase_q <= PH_IDLE;
							end
						end
					end
					PH_DATA: begin
						acc_q <= sum;
						if (carry) begin
							code_q <= code_next;
							cnt_q  <= cnt_next;
							if (last_bit) begin
								phase_q <= PH_STOP;
								acc_q   <= '0;
							end
						end
					end
					PH_STOP: begin
						acc_q <= sum;
						if (carry) begin
							phase_q <= PH_IDLE;
						end
					end
					default: begin
						phase_q <= PH_IDLE;
					end
				endcase
			end
		end
	end

	// bit counter never runs past the code length while framing data
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (cnt_q < BITS_PER_CODE))
		else $error("bit count out of range in data phase");

	// a code word only leaves on the sample that ends the data phase
	a_push_ends_data: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |=> (phase_q == PH_STOP))
		else $error("code pushed without moving to stop");

endmodule

>>> src/bdf_queue.sv
// short code word queue between framing front end and decoding back end
module bdf_queue #(
	parameter int unsigned DEPTH = bdf_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bdf_pkg::code_word_t push,
	input  logic                pop,
	output logic                full,
	output bdf_pkg::code_word_t head
);
	import bdf_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	code_t           mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.code  = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// the front end holds input while full, so no word is ever dropped
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> !full)
		else $error("code word pushed into full queue");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count out of range");

endmodule

>>> src/bdf_back.sv
// back end: letters/figures shift tracking, table lookup, output register
module bdf_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bdf_pkg::code_word_t            head,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bdf_pkg::CHAR_WIDTH-1:0] char_code
);
	import bdf_pkg::*;

	logic  out_valid_q;
	char_t char_q;
	logic  figures_q;
	logic  free;
	char_t looked_up;
	logic  is_shift;
	logic  emit;

	assign free      = !out_valid_q || !out_stall;
	assign pop       = head.valid && free;
	assign looked_up = ita2_lookup(figures_q, head.code);
	assign is_shift  = (head.code == CODE_LTRS) || (head.code == CODE_FIGS);
	assign emit      = !is_shift && (looked_up != CHAR_SPACE);

	assign out_valid = out_valid_q;
	assign char_code = char_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			figures_q   <= 1'b0;
		end else begin
			if (free) begin
				out_valid_q <= pop && emit;
			end
			if (pop && (head.code == CODE_LTRS)) begin
				figures_q <= 1'b0;
			end else if (pop && (head.code == CODE_FIGS)) begin
				figures_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && emit) begin
			char_q <= looked_up;
		end
	end

	a_no_space_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (char_q != CHAR_SPACE))
		else $error("space character emitted");

	// a shift code changes the case and never produces a character
	a_shift_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && is_shift && !out_valid_q) |=> !out_valid_q)
		else $error("shift code produced a character");

endmodule

>>> src/baudot_nco_deframer_top.sv
// Asynchronous ITA2 receiver: one sliced line sample per input word, one ASCII
// character per output word.
// Input channel: line_bit with in_valid/in_stall, 1 = mark, 0 = space. One
// sample is taken every cycle; in_stall rises only while the two-entry code
// queue between framer and decoder is full.
// Output channel: char_code with out_valid/out_stall from an output register.
// Throughput is one sample per cycle while in_stall is low. The code word of
// the sample that ends the fifth data bit is registered in the queue, then goes
// through the table lookup into the output register.
// Configuration: baud_step is written through cfg_valid/cfg_ready; ready is
// always high. Write it only while the line is idle and all characters have
// been taken.
// Reset: framer idle, accumulator and bit count cleared, letters case,
// baud_step back to its default, queue and output empty.
// While out_stall is high the output word holds; the queue absorbs up to two
// codes, after which in_stall holds off further samples.
module baudot_nco_deframer_top #(
	parameter int unsigned PHASE_WIDTH = bdf_pkg::PHASE_WIDTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bdf_pkg::STEP_WIDTH-1:0] baud_step,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           line_bit,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bdf_pkg::CHAR_WIDTH-1:0] char_code
);
	import bdf_pkg::*;

	code_word_t push;
	code_word_t head;
	logic       queue_full;
	logic       pop;

	assign cfg_ready = 1'b1;
	assign in_stall  = queue_full;

	bdf_front #(
		.PHASE_WIDTH(PHASE_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.baud_step (baud_step),
		.in_valid  (in_valid),
		.line_bit  (line_bit),
		.queue_full(queue_full),
		.push      (push)
	);

	bdf_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.pop   (pop),
		.full  (queue_full),
		.head  (head)
	);

	bdf_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.char_code(char_code)
	);

endmodule

>>> verif/tb_top.sv
// testbench for the baudot deframer: framed line samples in, decoded characters checked
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import bdf_pkg::*;

	localparam logic [31:0] STEP_HALF      = 32'h8000_0000;
	localparam logic [31:0] STEP_QUARTER   = 32'h4000_0000;
	localparam logic [31:0] STEP_MAX       = 32'hFFFF_FFFF;
	localparam logic [31:0] STEP_ZERO      = 32'h0000_0000;
	localparam int unsigned RANDOM_SAMPLES = 700;
	localparam int unsigned LONG_HOLD      = 400;
	localparam int unsigned SETTLE_CYCLES  = 8;

	typedef enum logic [1:0] {FR_IDLE, FR_START, FR_DATA, FR_STOP} fr_phase_t;
	typedef enum logic [1:0] {ROW_IDLE, ROW_FRAME, ROW_FALSE} row_kind_t;
	typedef enum logic [1:0] {EXP_NONE, EXP_CHAR, EXP_PRED} row_exp_t;

	typedef struct {
		logic        do_cfg;
		logic [31:0] cfg_val;
		row_kind_t   kind;
		code_t       code;
		int unsigned spb;
		int unsigned tail;
		row_exp_t    expect_kind;
		char_t       ch;
	} stim_row_t;

	// ita2 letters and figures cases
	localparam char_t LETTERS_MAP [32] = '{
		7'h20, 7'h20, 7'h45, 7'h0A, 7'h41, 7'h20, 7'h53, 7'h49,
		7'h55, 7'h0D, 7'h44, 7'h52, 7'h4A, 7'h4E, 7'h46, 7'h43,
		7'h4B, 7'h54, 7'h5A, 7'h4C, 7'h57, 7'h48, 7'h59, 7'h50,
		7'h51, 7'h4F, 7'h42, 7'h47, 7'h20, 7'h4D, 7'h58, 7'h56
	};
	localparam char_t FIGURES_MAP [32] = '{
		7'h20, 7'h20, 7'h33, 7'h0A, 7'h2D, 7'h20, 7'h38, 7'h37,
		7'h27, 7'h37, 7'h34, 7'h20, 7'h34, 7'h35, 7'h2C, 7'h3A,
		7'h21, 7'h3F, 7'h20, 7'h22, 7'h39, 7'h30, 7'h2B, 7'h31,
		7'h35, 7'h36, 7'h31, 7'h20, 7'h31, 7'h32, 7'h20, 7'h20
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] baud_step = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        line_bit = 1'b1;
	logic        out_valid;
	logic        out_stall = 1'b0;
	char_t       char_code;

	// per-sample tags riding along with line_bit
	logic  in_typed = 1'b0;
	logic  in_typed_has = 1'b0;
	char_t in_typed_ch = '0;

	// predictor state
	fr_phase_t   rx_phase;
	logic [31:0] rx_acc;
	code_t       rx_code;
	logic [2:0]  rx_taken;
	logic        rx_figures;
	logic [31:0] rx_step;

	char_t       pending_chars[$];
	stim_row_t   directed_rows[$];
	int unsigned mismatch_count = 0;
	int unsigned sent_count = 0;
	logic        in_idle = 1'b1;
	logic        out_idle = 1'b1;
	logic        jitter_on = 1'b0;
	logic        hold_req = 1'b0;
	logic        cur_typed = 1'b0;
	logic        cur_has = 1'b0;
	char_t       cur_ch = '0;

	baudot_nco_deframer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.baud_step (baud_step),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.line_bit  (line_bit),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.char_code (char_code)
	);

	always #2 clk = ~clk;

	function automatic void deframe_sample(input logic b, output logic got, output char_t ch,
			output logic ended);
		logic [32:0] sum;
		logic        carry;
		code_t       code;
		got = 1'b0;
		ended = 1'b0;
		ch = '0;
		sum = {1'b0, rx_acc} + {1'b0, rx_step};
		carry = sum[32];
		if (rx_phase != FR_IDLE) begin
			rx_acc = sum[31:0];
		end
		case (rx_phase)
			FR_IDLE: begin
				// space in idle: preload half scale to sample mid start bit
				if (!b) begin
					rx_phase = FR_START;
					rx_acc = 32'h8000_0000;
				end
			end
			FR_START: begin
				if (carry) begin
					if (!b) begin
						rx_phase = FR_DATA;
						rx_taken = '0;
						rx_code = '0;
						rx_acc = '0;
					end else begin
						rx_phase = FR_IDLE;
					end
				end
			end
			FR_DATA: begin
				if (carry) begin
					rx_code[rx_taken] = b;
					rx_taken = rx_taken + 3'd1;
					if (rx_taken == BITS_PER_CODE) begin
						ended = 1'b1;
						rx_phase = FR_STOP;
						rx_acc = '0;
						code = rx_code;
						if (code == CODE_LTRS) begin
							rx_figures = 1'b0;
						end else if (code == CODE_FIGS) begin
							rx_figures = 1'b1;
						end else if (code != CODE_NULL) begin
							ch = rx_figures ? FIGURES_MAP[code] : LETTERS_MAP[code];
							got = (ch != CHAR_SPACE);
						end
					end
				end
			end
			default: begin
				if (carry) begin
					rx_phase = FR_IDLE;
				end
			end
		endcase
	endfunction

	function automatic void log_failure(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%0t: %s", $realtime, msg);
		end
	endfunction

	function automatic void add_row(input logic do_cfg, input logic [31:0] cfg_val,
			input row_kind_t kind, input code_t code, input int unsigned spb,
			input int unsigned tail, input row_exp_t expect_kind, input char_t ch);
		stim_row_t r;
		r.do_cfg = do_cfg;
		r.cfg_val = cfg_val;
		r.kind = kind;
		r.code = code;
		r.spb = spb;
		r.tail = tail;
		r.expect_kind = expect_kind;
		r.ch = ch;
		directed_rows.push_back(r);
	endfunction

	function automatic int unsigned hold_len(input int unsigned spb);
		if (jitter_on && spb >= 3) begin
			return spb - 1 + $urandom_range(0, 2);
		end
		return spb;
	endfunction

	function automatic int unsigned bit_span(input logic [31:0] step);
		if (step == 0) begin
			return 2;
		end
		return int'((64'h1_0000_0000 + {32'd0, step} / 2) / {32'd0, step});
	endfunction

	// predictor: every accepted line sample
	always @(posedge clk) begin : sample_mon
		logic  got;
		logic  ended;
		char_t ch;
		if (arst_n && in_valid && !in_stall) begin
			deframe_sample(line_bit, got, ch, ended);
			if (in_typed) begin
				if (ended && in_typed_has) begin
					pending_chars.push_back(in_typed_ch);
				end
			end else if (got) begin
				pending_chars.push_back(ch);
			end
		end
	end

	always @(posedge clk) begin : char_mon
		char_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_chars.size() == 0) begin
				log_failure($sformatf("unexpected char %h", char_code));
			end else begin
				want = pending_chars.pop_front();
				if (char_code !== want) begin
					log_failure($sformatf("char mismatch: expected %h got %h", want, char_code));
				end
			end
		end
	end

	// receiver side: random stalls per word, one long hold on request
	initial begin : rx_side
		int unsigned n;
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				n = LONG_HOLD;
			end else begin
				n = out_idle ? $urandom_range(0, 15) : 0;
			end
			if (n != 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!(out_valid && !out_stall)) @(posedge clk);
		end
	end

	initial begin : watchdog
		#(2_000_000);
		$display("*** FAILED ***");
		$finish;
	end

	task automatic send_bit(input logic b);
		int unsigned gap;
		gap = in_idle ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		line_bit <= b;
		in_typed <= cur_typed;
		in_typed_has <= cur_has;
		in_typed_ch <= cur_ch;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent_count++;
	endtask

	task automatic send_level(input logic b, input int unsigned n);
		repeat (n) send_bit(b);
	endtask

	task automatic send_frame(input code_t code, input int unsigned spb, input int unsigned nbits,
			input int unsigned tail);
		send_level(1'b0, hold_len(spb));
		for (int k = 0; k < nbits; k++) begin
			send_level(code[k], hold_len(spb));
		end
		if (nbits == 5) begin
			send_level(1'b1, hold_len(spb));
		end
		send_level(1'b1, tail);
	endtask

	// wait until every expected word is out, then let the pipe settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_step(input logic [31:0] v);
		drain();
		cfg_valid <= 1'b1;
		baud_step <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		rx_step = v;
	endtask

	initial begin : stimulus
		stim_row_t   r;
		logic [31:0] step;
		int unsigned spb;
		int unsigned base;
		int unsigned seg;
		int unsigned nframes;
		int unsigned sel;
		code_t       code;

		rx_phase = FR_IDLE;
		rx_acc = '0;
		rx_code = '0;
		rx_taken = '0;
		rx_figures = 1'b0;
		rx_step = BAUD_STEP_RESET;

		// idle marks at the reset step, then the special cases, mostly at two samples per bit
		add_row(0, '0, ROW_IDLE, '0, 2, 8, EXP_NONE, '0);
		add_row(1, STEP_HALF, ROW_FRAME, 5'h02, 2, 1, EXP_CHAR, 7'h45);
		add_row(0, '0, ROW_FRAME, CODE_LTRS, 2, 1, EXP_NONE, '0);
		add_row(0, '0, ROW_FRAME, CODE_NULL, 2, 1, EXP_NONE, '0);
		add_row(0, '0, ROW_FRAME, 5'h05, 2, 0, EXP_NONE, '0);
		add_row(0, '0, ROW_FRAME, 5'h03, 2, 1, EXP_CHAR, 7'h0A);
		add_row(0, '0, ROW_FRAME, 5'h09, 2, 1, EXP_CHAR, 7'h0D);
		add_row(0, '0, ROW_FALSE, '0, 2, 6, EXP_NONE, '0);
		add_row(0, '0, ROW_FRAME, CODE_FIGS, 2, 1, EXP_NONE, '0);
		add_row(0, '0, ROW_FRAME, 5'h04, 2, 1, EXP_CHAR, 7'h2D);
		add_row(0, '0, ROW_FRAME, 5'h0B, 2, 1, EXP_NONE, '0);
		add_row(0, '0, ROW_FRAME, 5'h1D, 2, 1, EXP_CHAR, 7'h32);
		add_row(0, '0, ROW_FRAME, 5'h11, 2, 1, EXP_CHAR, 7'h3F);
		add_row(0, '0, ROW_FRAME, CODE_LTRS, 2, 1, EXP_NONE, '0);
		add_row(0, '0, ROW_FRAME, 5'h1E, 2, 1, EXP_CHAR, 7'h58);
		add_row(0, '0, ROW_FRAME, 5'h18, 2, 1, EXP_CHAR, 7'h51);
		add_row(1, STEP_MAX, ROW_FRAME, CODE_LTRS, 1, 4, EXP_PRED, '0);
		add_row(0, '0, ROW_FRAME, 5'h10, 1, 4, EXP_PRED, '0);
		// zero step: a space leaves the framer stuck until the next step write
		add_row(1, STEP_ZERO, ROW_FALSE, '0, 2, 6, EXP_NONE, '0);
		add_row(1, STEP_HALF, ROW_IDLE, '0, 2, 4, EXP_NONE, '0);
		add_row(0, '0, ROW_FRAME, CODE_LTRS, 2, 1, EXP_NONE, '0);
		add_row(0, '0, ROW_FRAME, 5'h1C, 2, 1, EXP_NONE, '0);
		add_row(1, STEP_QUARTER, ROW_FRAME, 5'h0F, 4, 1, EXP_CHAR, 7'h43);
		add_row(0, '0, ROW_FRAME, 5'h1A, 4, 2, EXP_CHAR, 7'h42);

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			if (r.do_cfg) begin
				write_step(r.cfg_val);
			end
			cur_typed = (r.expect_kind != EXP_PRED);
			cur_has = (r.expect_kind == EXP_CHAR);
			cur_ch = r.ch;
			case (r.kind)
				ROW_IDLE:  send_level(1'b1, r.tail);
				ROW_FALSE: begin
					send_bit(1'b0);
					send_level(1'b1, r.tail);
				end
				default:   send_frame(r.code, r.spb, 5, r.tail);
			endcase
		end
		cur_typed = 1'b0;
		cur_has = 1'b0;

		// random part: segments of frames at one step setting each
		jitter_on = 1'b1;
		base = sent_count;
		seg = 0;
		while (sent_count - base < RANDOM_SAMPLES) begin
			sel = $urandom_range(0, 11);
			if (sel == 0) begin
				step = STEP_MAX;
			end else if (sel == 1) begin
				step = $urandom_range(32'hFFFF_FFFF, 32'h2000_0000);
			end else if (sel == 2 && seg > 2) begin
				step = STEP_ZERO;
			end else if (sel < 6) begin
				step = 32'h5555_5555;
			end else if (sel < 8) begin
				step = STEP_QUARTER;
			end else begin
				step = STEP_HALF;
			end
			// the long hold needs a step that surely frames characters
			if (seg == 2) begin
				step = STEP_HALF;
			end
			write_step(step);
			spb = bit_span(step);
			in_idle = ($urandom_range(0, 2) != 0);
			out_idle = ($urandom_range(0, 2) != 0);
			nframes = $urandom_range(4, 12);
			if (seg == 2) begin
				// long receiver hold while the sender keeps pushing
				in_idle = 1'b0;
				hold_req = 1'b1;
				nframes = 24;
			end
			if (step == STEP_ZERO) begin
				send_level(1'b1, $urandom_range(0, 3));
				repeat ($urandom_range(4, 12)) send_bit(1'($urandom_range(0, 1)));
				nframes = 0;
			end
			for (int f = 0; f < nframes; f++) begin
				sel = $urandom_range(0, 19);
				if (seg == 5 && f == nframes / 2) begin
					drain();
				end
				if (sel == 0) begin
					repeat ($urandom_range(1, 12)) send_bit(1'($urandom_range(0, 1)));
				end else if (sel == 1) begin
					send_level(1'b0, $urandom_range(1, (spb + 1) / 2));
					send_level(1'b1, spb + 2);
				end else if (sel == 2) begin
					send_frame(code_t'($urandom_range(0, 31)), spb, $urandom_range(0, 4),
						$urandom_range(1, 3 * spb));
				end else begin
					if (sel < 6) begin
						code = CODE_LTRS;
					end else if (sel < 9) begin
						code = CODE_FIGS;
					end else begin
						code = code_t'($urandom_range(0, 31));
					end
					send_frame(code, spb, 5, $urandom_range(0, spb));
				end
			end
			seg++;
		end

		in_valid <= 1'b0;
		while (pending_chars.size() != 0) @(posedge clk);
		repeat (4 * SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_chars.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
